/* sv/mm4_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mm4_pkg: shared types and constants of the 4x4 matrix multiplier
// Holds the request and response word layouts, command codes, saturation
// limits and the microcode program that drives the multiply datapath.
// ----------------------------------------------------------------------------
package mm4_pkg;

	// Default number of fraction bits of the fixed-point format.
	localparam int FRAC_BITS_DEF = 16;

	localparam int DATA_W = 32;
	localparam int IDX_W  = 4;
	localparam int PROD_W = 2 * DATA_W;
	// Four products summed need two more bits than one product.
	localparam int ACC_W  = PROD_W + 2;

	localparam logic [DATA_W-1:0] SAT_MAX = 32'h7FFF_FFFF;
	localparam logic [DATA_W-1:0] SAT_MIN = 32'h8000_0000;

	// Command codes carried by a request word.
	typedef enum logic [1:0] {
		CMD_WR_A = 2'd0,
		CMD_WR_B = 2'd1,
		CMD_MUL  = 2'd2,
		CMD_NOP  = 2'd3
	} cmd_t;

	typedef struct packed {
		logic [1:0]               cmd;
		logic [IDX_W-1:0]         elem_index;
		logic signed [DATA_W-1:0] elem_value;
	} req_word_t;

	typedef struct packed {
		logic [IDX_W-1:0]         out_index;
		logic signed [DATA_W-1:0] product_value;
		logic                     last;
	} rsp_word_t;

	// Microprogram counter and its step addresses.
	typedef logic [2:0] upc_t;
	localparam upc_t UPC_IDLE = 3'd0;
	localparam upc_t UPC_CLR  = 3'd1;
	localparam upc_t UPC_RD   = 3'd2;
	localparam upc_t UPC_MUL  = 3'd3;
	localparam upc_t UPC_ACC  = 3'd4;
	localparam upc_t UPC_EMIT = 3'd5;
	localparam int   UCODE_LEN = 6;

	// Branch conditions evaluated at the end of each step.
	typedef enum logic [1:0] {
		COND_NEXT   = 2'd0, // fall through to the next step
		COND_START  = 2'd1, // jump on an accepted multiply, else stay
		COND_K_MORE = 2'd2, // jump while more products remain
		COND_EMIT   = 2'd3  // stay while blocked, jump while elements remain
	} cond_t;

	// One control word of the microprogram.
	typedef struct packed {
		logic  idle;
		logic  clr;
		logic  mul;
		logic  acc;
		logic  emit;
		cond_t cond;
		upc_t  target;
	} ctl_word_t;

	localparam ctl_word_t UCODE [UCODE_LEN] = '{
		'{idle: 1'b1, clr: 1'b0, mul: 1'b0, acc: 1'b0, emit: 1'b0,
			cond: COND_START,  target: UPC_CLR},
		'{idle: 1'b0, clr: 1'b1, mul: 1'b0, acc: 1'b0, emit: 1'b0,
			cond: COND_NEXT,   target: UPC_RD},
		'{idle: 1'b0, clr: 1'b0, mul: 1'b0, acc: 1'b0, emit: 1'b0,
			cond: COND_NEXT,   target: UPC_MUL},
		'{idle: 1'b0, clr: 1'b0, mul: 1'b1, acc: 1'b0, emit: 1'b0,
			cond: COND_NEXT,   target: UPC_ACC},
		'{idle: 1'b0, clr: 1'b0, mul: 1'b0, acc: 1'b1, emit: 1'b0,
			cond: COND_K_MORE, target: UPC_RD},
		'{idle: 1'b0, clr: 1'b0, mul: 1'b0, acc: 1'b0, emit: 1'b1,
			cond: COND_EMIT,   target: UPC_CLR}
	};

endpackage

/* sv/mm4_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mm4_req_if / mm4_rsp_if: valid/ready channels of the matrix multiplier
// The request channel carries commands and element writes; the response
// channel carries product elements.
// ----------------------------------------------------------------------------
interface mm4_req_if
	import mm4_pkg::*;
();
	logic                     valid;
	logic                     ready;
	logic [1:0]               cmd;
	logic [IDX_W-1:0]         elem_index;
	logic signed [DATA_W-1:0] elem_value;

	modport source (output valid, output cmd, output elem_index, output elem_value,
		input ready);
	modport sink (input valid, input cmd, input elem_index, input elem_value,
		output ready);
endinterface

interface mm4_rsp_if
	import mm4_pkg::*;
();
	logic                     valid;
	logic                     ready;
	logic [IDX_W-1:0]         out_index;
	logic signed [DATA_W-1:0] product_value;
	logic                     last;

	modport source (output valid, output out_index, output product_value, output last,
		input ready);
	modport sink (input valid, input out_index, input product_value, input last,
		output ready);
endinterface

/* sv/matrix4_multiply.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// matrix4_multiply: 4x4 signed fixed-point matrix product
// Microcoded multiply-accumulate engine over two 16-entry element memories.
// ----------------------------------------------------------------------------
// Usage:
// The req channel takes one word per accepted handshake. Command write A or
// write B stores elem_value at column-major elem_index (row + 4*column) and
// gives no response. Command multiply starts a run that sends sixteen
// words on the rsp channel, product elements in column-major order,
// with last set on the sixteenth. The unused command code is taken and
// dropped.
// Each product element takes four multiply-accumulate passes of three steps
// (read, multiply, accumulate) on one shared 32x32 multiplier, plus a clear
// step and an emit step. req.ready is high only while the sequencer idles.
// A single output register holds each word; while the receiver stalls the
// sequencer waits in its emit step and nothing is lost.
// Reset loads both matrices with the identity through per-entry valid bits
// and needs no clearing pass; the block is ready as soon as reset is released.
// ----------------------------------------------------------------------------
module matrix4_multiply
	import mm4_pkg::*;
#(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	mm4_req_if.sink    req,
	mm4_rsp_if.source  rsp
);

	localparam int NUM_ELEM = 1 << IDX_W;
	localparam logic [DATA_W-1:0] ONE_VAL = DATA_W'(1) << FRAC_BITS;

	// Sequencer state.
	upc_t             upc_q;
	upc_t             upc_nxt;
	ctl_word_t        ctl;
	logic [1:0]       k_q;
	logic [IDX_W-1:0] e_q;

	// Element memories and their valid bits.
	logic [DATA_W-1:0]   mem_a [NUM_ELEM];
	logic [DATA_W-1:0]   mem_b [NUM_ELEM];
	logic [NUM_ELEM-1:0] vld_a_q;
	logic [NUM_ELEM-1:0] vld_b_q;

	// Datapath.
	logic [IDX_W-1:0]         addr_a;
	logic [IDX_W-1:0]         addr_b;
	logic [DATA_W-1:0]        rd_a_s1;
	logic [DATA_W-1:0]        rd_b_s1;
	logic                     vld_a_s1;
	logic                     vld_b_s1;
	logic                     diag_a_s1;
	logic                     diag_b_s1;
	logic signed [DATA_W-1:0] op_a;
	logic signed [DATA_W-1:0] op_b;
	logic signed [PROD_W-1:0] prod_s2;
	logic signed [ACC_W-1:0]  acc_q;
	logic signed [ACC_W-1:0]  acc_sh;
	logic [DATA_W-1:0]        sat_val;

	// Output register.
	logic              out_valid_q;
	logic [IDX_W-1:0]  out_index_q;
	logic [DATA_W-1:0] out_value_q;
	logic              out_last_q;

	logic req_fire;
	logic emit_fire;

	assign ctl       = UCODE[upc_q];
	assign req.ready = ctl.idle;
	assign req_fire  = req.valid && req.ready;
	assign emit_fire = ctl.emit && (!out_valid_q || rsp.ready);

	// Next step: evaluate the branch condition of the current control word.
	always_comb begin
		upc_nxt = upc_q + upc_t'(1);
		unique case (ctl.cond)
			COND_NEXT: begin
				upc_nxt = upc_q + upc_t'(1);
			end
			COND_START: begin
				upc_nxt = (req_fire && req.cmd == CMD_MUL) ? ctl.target : upc_q;
			end
			COND_K_MORE: begin
				upc_nxt = (k_q != 2'd3) ? ctl.target : upc_q + upc_t'(1);
			end
			COND_EMIT: begin
				if (!emit_fire) begin
					upc_nxt = upc_q;
				end else if (e_q != IDX_W'(NUM_ELEM - 1)) begin
					upc_nxt = ctl.target;
				end else begin
					upc_nxt = UPC_IDLE;
				end
			end
			default: begin
				upc_nxt = UPC_IDLE;
			end
		endcase
	end

	// Step counter and loop counters.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			upc_q <= UPC_IDLE;
			k_q   <= '0;
			e_q   <= '0;
		end else begin
			upc_q <= upc_nxt;
			if (ctl.idle) begin
				e_q <= '0;
			end else if (emit_fire) begin
				e_q <= e_q + IDX_W'(1);
			end
			if (ctl.clr) begin
				k_q <= '0;
			end else if (ctl.acc) begin
				k_q <= k_q + 2'd1;
			end
		end
	end

	// A runs along row e[1:0], B down column e[3:2].
	assign addr_a = {k_q, e_q[1:0]};
	assign addr_b = {e_q[3:2], k_q};

	// Element memories: one write port, one registered read port each.
	always_ff @(posedge clk) begin
		if (req_fire && req.cmd == CMD_WR_A) begin
			mem_a[req.elem_index] <= req.elem_value;
		end
		if (req_fire && req.cmd == CMD_WR_B) begin
			mem_b[req.elem_index] <= req.elem_value;
		end
		rd_a_s1   <= mem_a[addr_a];
		rd_b_s1   <= mem_b[addr_b];
		vld_a_s1  <= vld_a_q[addr_a];
		vld_b_s1  <= vld_b_q[addr_b];
		diag_a_s1 <= (addr_a[1:0] == addr_a[3:2]);
		diag_b_s1 <= (addr_b[1:0] == addr_b[3:2]);
	end

	// Valid bits: an entry never written reads as the identity element.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_a_q <= '0;
			vld_b_q <= '0;
		end else begin
			if (req_fire && req.cmd == CMD_WR_A) begin
				vld_a_q[req.elem_index] <= 1'b1;
			end
			if (req_fire && req.cmd == CMD_WR_B) begin
				vld_b_q[req.elem_index] <= 1'b1;
			end
		end
	end

	assign op_a = vld_a_s1 ? rd_a_s1 : (diag_a_s1 ? ONE_VAL : '0);
	assign op_b = vld_b_s1 ? rd_b_s1 : (diag_b_s1 ? ONE_VAL : '0);

	// Multiply and accumulate at full precision.
	always_ff @(posedge clk) begin
		if (ctl.mul) begin
			prod_s2 <= op_a * op_b;
		end
		if (ctl.clr) begin
			acc_q <= '0;
		end else if (ctl.acc) begin
			acc_q <= acc_q + {{(ACC_W - PROD_W){prod_s2[PROD_W-1]}}, prod_s2};
		end
	end

	// Scale down with truncation toward minus infinity, then saturate.
	assign acc_sh = acc_q >>> FRAC_BITS;

	always_comb begin
		if ((&acc_sh[ACC_W-1:DATA_W-1]) || !(|acc_sh[ACC_W-1:DATA_W-1])) begin
			sat_val = acc_sh[DATA_W-1:0];
		end else if (acc_sh[ACC_W-1]) begin
			sat_val = SAT_MIN;
		end else begin
			sat_val = SAT_MAX;
		end
	end

	// Output register: valid under reset, payload loaded on emit.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit_fire) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_fire) begin
			out_index_q <= e_q;
			out_value_q <= sat_val;
			out_last_q  <= (e_q == IDX_W'(NUM_ELEM - 1));
		end
	end

	assign rsp.valid         = out_valid_q;
	assign rsp.out_index     = out_index_q;
	assign rsp.product_value = out_value_q;
	assign rsp.last          = out_last_q;

	// A word marked last always carries the final element index.
	a_last_index: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_last_q) |-> (out_index_q == IDX_W'(NUM_ELEM - 1)))
		else $error("last word carries wrong index");

	// An accumulate step always follows its multiply step.
	a_acc_after_mul: assert property (@(posedge clk) disable iff (!arst_n)
		(upc_q == UPC_ACC) |-> ($past(upc_q) == UPC_MUL))
		else $error("accumulate without multiply");

	// A taken multiply starts at the first element with a cleared step.
	a_mul_start: assert property (@(posedge clk) disable iff (!arst_n)
		(req_fire && req.cmd == CMD_MUL) |=> (upc_q == UPC_CLR && e_q == '0))
		else $error("multiply did not start cleanly");

	// An emitted element is presented on the next cycle.
	a_emit_shown: assert property (@(posedge clk) disable iff (!arst_n)
		emit_fire |=> out_valid_q)
		else $error("emitted element not presented");

endmodule

/* tb/tb_matrix4_multiply.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_matrix4_multiply: self-checking bench for the 4x4 Q16.16 matrix product
// A short table of directed words (identity after reset, the unused command,
// saturation at both limits, truncation of a negative sum) is followed by
// random element writes and multiplies. Every product element is compared
// with a local fixed-point model; both channels idle and stall at random.
// ----------------------------------------------------------------------------
module tb_matrix4_multiply;
	import mm4_pkg::*;

	localparam int FRAC       = FRAC_BITS_DEF;
	localparam int RAND_WORDS = 190;
	localparam int STALL_MAX  = 3000;
	localparam logic signed [65:0] Q_HI = 66'sd2147483647;
	localparam logic signed [65:0] Q_LO = -66'sd2147483648;

	// One directed word; diag holds the typed diagonal of a diagonal product.
	typedef struct packed {
		cmd_t             cmd;
		logic [3:0]       idx;
		logic [31:0]      value;
		logic             typed;
		logic [0:3][31:0] diag;
	} stim_row_t;

	localparam int N_ROWS = 22;
	localparam stim_row_t DIRECTED [N_ROWS] = '{
		'{CMD_MUL,  4'd0,  32'h0000_0000, 1'b1,
			{32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000}},
		'{CMD_NOP,  4'd15, 32'hFFFF_FFFF, 1'b0, '0},
		'{CMD_MUL,  4'd15, 32'hA5A5_5A5A, 1'b1,
			{32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000}},
		'{CMD_WR_A, 4'd0,  32'h7FFF_FFFF, 1'b0, '0},
		'{CMD_WR_A, 4'd5,  32'h7FFF_FFFF, 1'b0, '0},
		'{CMD_WR_A, 4'd10, 32'h8000_0000, 1'b0, '0},
		'{CMD_WR_A, 4'd15, 32'h8000_0000, 1'b0, '0},
		'{CMD_WR_B, 4'd0,  32'h7FFF_FFFF, 1'b0, '0},
		'{CMD_WR_B, 4'd5,  32'h8000_0000, 1'b0, '0},
		'{CMD_WR_B, 4'd10, 32'h8000_0000, 1'b0, '0},
		'{CMD_WR_B, 4'd15, 32'h7FFF_FFFF, 1'b0, '0},
		'{CMD_MUL,  4'd7,  32'h0000_0000, 1'b1,
			{32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000}},
		'{CMD_WR_A, 4'd0,  32'hFFFF_FFFF, 1'b0, '0},
		'{CMD_WR_B, 4'd0,  32'h0000_0001, 1'b0, '0},
		'{CMD_MUL,  4'd0,  32'hFFFF_FFFF, 1'b1,
			{32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000}},
		'{CMD_WR_A, 4'd4,  32'h0002_0000, 1'b0, '0},
		'{CMD_WR_B, 4'd1,  32'hFFFD_0000, 1'b0, '0},
		'{CMD_WR_B, 4'd14, 32'h0000_8000, 1'b0, '0},
		'{CMD_WR_A, 4'd8,  32'hFFFF_8000, 1'b0, '0},
		'{CMD_MUL,  4'd3,  32'h1234_5678, 1'b0, '0},
		'{CMD_NOP,  4'd0,  32'h0000_0000, 1'b0, '0},
		'{CMD_MUL,  4'd12, 32'h0000_0000, 1'b0, '0}
	};

	logic clk;
	logic arst_n;

	mm4_req_if req_ch ();
	mm4_rsp_if rsp_ch ();

	matrix4_multiply dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	// Local copy of both matrices and the products still owed by the block.
	logic signed [31:0] mat_a [16];
	logic signed [31:0] mat_b [16];
	rsp_word_t          expected_products [$];

	int mismatch_count;
	int words_sent;
	int multiplies;
	int products_checked;
	int saturated_seen;
	int stall_cycles;
	int burst_left;

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// One product element: full-width sum, arithmetic shift, saturation.
	function automatic logic [31:0] product_elem(input int row, input int col);
		logic signed [65:0] acc;
		logic signed [63:0] term;
		logic signed [65:0] scaled;
		acc = '0;
		for (int k = 0; k < 4; k++) begin
			term = mat_a[row + 4 * k] * mat_b[k + 4 * col];
			acc  = acc + term;
		end
		scaled = acc >>> FRAC;
		if (scaled > Q_HI)
			return SAT_MAX;
		if (scaled < Q_LO)
			return SAT_MIN;
		return scaled[31:0];
	endfunction

	// Sender pacing: bursts of random length separated by random gaps.
	task automatic pace();
		int gap;
		if (burst_left == 0) begin
			gap = $urandom_range(0, 5);
			if (gap > 0) begin
				req_ch.valid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			burst_left = $urandom_range(1, 12);
		end
		burst_left--;
	endtask

	// Drive one word, wait for the handshake, then update the local matrices or queue the expected products.
	task automatic send_word(input cmd_t c, input logic [3:0] idx, input logic [31:0] value,
		input logic typed, input logic [0:3][31:0] diag);
		rsp_word_t elem;
		req_ch.valid      <= 1'b1;
		req_ch.cmd        <= c;
		req_ch.elem_index <= idx;
		req_ch.elem_value <= value;
		do @(posedge clk); while (!req_ch.ready);
		words_sent++;
		case (c)
			CMD_WR_A: mat_a[idx] = value;
			CMD_WR_B: mat_b[idx] = value;
			CMD_MUL: begin
				multiplies++;
				for (int i = 0; i < 16; i++) begin
					elem.out_index = i[3:0];
					if (typed)
						elem.product_value = (i % 5 == 0) ? diag[i / 5] : 32'h0;
					else
						elem.product_value = product_elem(i & 3, i >> 2);
					elem.last = (i == 15);
					expected_products.push_back(elem);
				end
			end
			default: ;
		endcase
		@(negedge clk);
	endtask

	// Hold the request channel idle until every owed product has come back.
	task automatic drain();
		req_ch.valid <= 1'b0;
		do @(negedge clk); while (expected_products.size() != 0);
	endtask

	function automatic logic [31:0] random_value();
		logic [31:0] pick;
		case ($urandom_range(0, 3))
			0: pick = $urandom;
			1: pick = $urandom_range(0, 32'h0004_0000) - 32'h0002_0000;
			2: begin
				case ($urandom_range(0, 5))
					0: pick = 32'h7FFF_FFFF;
					1: pick = 32'h8000_0000;
					2: pick = 32'hFFFF_FFFF;
					3: pick = 32'h0000_0000;
					4: pick = 32'h0001_0000;
					default: pick = 32'hFFFF_0000;
				endcase
			end
			default: pick = $urandom_range(0, 32'h0200_0000) - 32'h0100_0000;
		endcase
		return pick;
	endfunction

	// Request side: reset, directed table, random words with a drain halfway, final drain.
	initial begin
		cmd_t        c;
		int          roll;
		int          counted;
		logic [31:0] v;
		arst_n            <= 1'b0;
		req_ch.valid      <= 1'b0;
		req_ch.cmd        <= CMD_NOP;
		req_ch.elem_index <= '0;
		req_ch.elem_value <= '0;
		mismatch_count   = 0;
		words_sent       = 0;
		multiplies       = 0;
		products_checked = 0;
		saturated_seen   = 0;
		burst_left       = 0;
		counted          = 0;
		for (int i = 0; i < 16; i++) begin
			mat_a[i] = (i % 5 == 0) ? (32'sd1 <<< FRAC) : 32'sd0;
			mat_b[i] = mat_a[i];
		end
		repeat (8) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		for (int r = 0; r < N_ROWS; r++) begin
			pace();
			send_word(DIRECTED[r].cmd, DIRECTED[r].idx, DIRECTED[r].value,
				DIRECTED[r].typed, DIRECTED[r].diag);
		end

		// Mostly element writes, a multiply now and then, a few unused commands.
		while (counted < RAND_WORDS) begin
			if (counted == RAND_WORDS / 2)
				drain();
			roll = $urandom_range(0, 99);
			if (roll < 5)
				c = CMD_NOP;
			else if (roll < 13)
				c = CMD_MUL;
			else if (roll < 56)
				c = CMD_WR_A;
			else
				c = CMD_WR_B;
			v = random_value();
			pace();
			send_word(c, 4'($urandom_range(0, 15)), v, 1'b0, '0);
			if (c != CMD_NOP)
				counted++;
		end

		drain();
		repeat (30) @(negedge clk);
		$display("Sent %0d words with %0d multiplies; checked %0d product elements,",
			words_sent, multiplies, products_checked);
		$display("%0d of them saturated, %0d mismatches.", saturated_seen, mismatch_count);
		if (mismatch_count == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

	// Response side: ready follows a randomly chosen mode: always high, random, a repeating mask or a periodic pattern.
	initial begin
		int          mode;
		logic [7:0]  mask;
		rsp_ch.ready <= 1'b0;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			mode = $urandom_range(0, 3);
			mask = 8'($urandom_range(1, 255));
			for (int n = 0; n < 64; n++) begin
				case (mode)
					0: rsp_ch.ready <= 1'b1;
					1: rsp_ch.ready <= 1'($urandom_range(0, 1));
					2: rsp_ch.ready <= mask[n % 8];
					default: rsp_ch.ready <= (n % 32) >= 20;
				endcase
				@(negedge clk);
			end
		end
	end

	// Compare each product word with the oldest expectation; watch for a hang.
	always @(posedge clk) begin
		rsp_word_t exp_word;
		if (!arst_n) begin
			stall_cycles = 0;
		end else begin
			if (rsp_ch.valid && rsp_ch.ready) begin
				if (expected_products.size() == 0) begin
					$error("product word index %0d with nothing expected", rsp_ch.out_index);
					mismatch_count++;
				end else begin
					exp_word = expected_products.pop_front();
					products_checked++;
					if (exp_word.product_value == SAT_MAX || exp_word.product_value == SAT_MIN)
						saturated_seen++;
					if (rsp_ch.out_index !== exp_word.out_index) begin
						$error("out_index: expected %0d, actual %0d",
							exp_word.out_index, rsp_ch.out_index);
						mismatch_count++;
					end
					if (rsp_ch.product_value !== exp_word.product_value) begin
						$error("product_value: expected %h, actual %h",
							exp_word.product_value, rsp_ch.product_value);
						mismatch_count++;
					end
					if (rsp_ch.last !== exp_word.last) begin
						$error("last: expected %b, actual %b", exp_word.last, rsp_ch.last);
						mismatch_count++;
					end
				end
			end
			if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
				stall_cycles = 0;
			else
				stall_cycles++;
			if (stall_cycles >= STALL_MAX) begin
				$display("Timeout: no word moved for %0d cycles.", STALL_MAX);
				$display("end of test: mismatches");
				$finish;
			end
		end
	end

endmodule
